/* hw/rtl/ntc_voltage_to_temperature_assert.svh */
// Assertion macros for the NTC voltage to temperature converter.
`ifndef NTC_VOLTAGE_TO_TEMPERATURE_ASSERT_SVH
`define NTC_VOLTAGE_TO_TEMPERATURE_ASSERT_SVH

// same-cycle implication
`define NTCVT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NTCVT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/ntcvt_pkg.sv */
// Shared types, constants and breakpoint table of the NTC converter.
package ntcvt_pkg;

   localparam int TABLE_POINTS = 33;
   localparam int IDX_W        = $clog2(TABLE_POINTS);
   localparam int MV_W         = 12;
   localparam int T_W          = 12;
   localparam int DT_W         = 11;
   localparam int PROD_W       = MV_W + DT_W;
   localparam int DCNT_W       = $clog2(PROD_W);
   localparam int CHAN_W       = 8;
   localparam int VIN_W        = 16;

   localparam logic [VIN_W-1:0] MV_MAX = 16'd2440;
   localparam logic [VIN_W-1:0] MV_MIN = 16'd1300;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_MULT,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_in;
      logic start_search;
      logic inc_idx;
      logic load_seg;
      logic load_prod;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic seg_hit;
      logic div_last;
      logic out_free;
   } stat_type;

   typedef struct packed {
      logic        [MV_W-1:0] mv;
      logic signed [T_W-1:0]  tenths;
   } bp_type;

   // breakpoints, voltage strictly descending
   function automatic bp_type bp_lookup(input logic [IDX_W-1:0] idx);
      bp_type bp;
      case (idx)
         6'd0:  bp = '{12'd2440, -12'sd400};
         6'd1:  bp = '{12'd2420, -12'sd350};
         6'd2:  bp = '{12'd2400, -12'sd300};
         6'd3:  bp = '{12'd2380, -12'sd250};
         6'd4:  bp = '{12'd2350, -12'sd200};
         6'd5:  bp = '{12'd2320, -12'sd150};
         6'd6:  bp = '{12'd2270, -12'sd100};
         6'd7:  bp = '{12'd2230, -12'sd50};
         6'd8:  bp = '{12'd2170, 12'sd0};
         6'd9:  bp = '{12'd2110, 12'sd50};
         6'd10: bp = '{12'd2050, 12'sd100};
         6'd11: bp = '{12'd1990, 12'sd150};
         6'd12: bp = '{12'd1920, 12'sd200};
         6'd13: bp = '{12'd1860, 12'sd250};
         6'd14: bp = '{12'd1800, 12'sd300};
         6'd15: bp = '{12'd1740, 12'sd350};
         6'd16: bp = '{12'd1680, 12'sd400};
         6'd17: bp = '{12'd1630, 12'sd450};
         6'd18: bp = '{12'd1590, 12'sd500};
         6'd19: bp = '{12'd1550, 12'sd550};
         6'd20: bp = '{12'd1510, 12'sd600};
         6'd21: bp = '{12'd1480, 12'sd650};
         6'd22: bp = '{12'd1450, 12'sd700};
         6'd23: bp = '{12'd1430, 12'sd750};
         6'd24: bp = '{12'd1400, 12'sd800};
         6'd25: bp = '{12'd1380, 12'sd850};
         6'd26: bp = '{12'd1370, 12'sd900};
         6'd27: bp = '{12'd1350, 12'sd950};
         6'd28: bp = '{12'd1340, 12'sd1000};
         6'd29: bp = '{12'd1330, 12'sd1050};
         6'd30: bp = '{12'd1320, 12'sd1100};
         6'd31: bp = '{12'd1310, 12'sd1150};
         6'd32: bp = '{12'd1300, 12'sd1200};
         default: bp = '{12'd0, 12'sd0};
      endcase
      return bp;
   endfunction

endpackage

/* hw/rtl/ntcvt_ctrl.sv */
// Sequencer for range check, segment search, multiply and serial divide.
module ntcvt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  ntcvt_pkg::stat_type stat,
   output ntcvt_pkg::cmd_type  cmd
);

   ntcvt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ntcvt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ntcvt_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = ntcvt_pkg::ST_CHECK;
         end
         ntcvt_pkg::ST_CHECK: begin
            if (stat.in_range) state_in = ntcvt_pkg::ST_SEARCH;
            else               state_in = ntcvt_pkg::ST_FINISH;
         end
         ntcvt_pkg::ST_SEARCH: begin
            if (stat.seg_hit) state_in = ntcvt_pkg::ST_MULT;
         end
         ntcvt_pkg::ST_MULT: begin
            state_in = ntcvt_pkg::ST_DIV;
         end
         ntcvt_pkg::ST_DIV: begin
            if (stat.div_last) state_in = ntcvt_pkg::ST_FINISH;
         end
         ntcvt_pkg::ST_FINISH: begin
            if (stat.out_free) state_in = ntcvt_pkg::ST_IDLE;
         end
         default: state_in = ntcvt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ntcvt_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         ntcvt_pkg::ST_CHECK: begin
            cmd.start_search = stat.in_range;
         end
         ntcvt_pkg::ST_SEARCH: begin
            cmd.load_seg = stat.seg_hit;
            cmd.inc_idx  = !stat.seg_hit;
         end
         ntcvt_pkg::ST_MULT: begin
            cmd.load_prod = 1'b1;
         end
         ntcvt_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ntcvt_pkg::ST_FINISH: begin
            cmd.load_out = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* hw/rtl/ntcvt_dp.sv */
// Datapath: input capture, segment search, interpolation and result register.
module ntcvt_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  ntcvt_pkg::cmd_type                  cmd,
   output ntcvt_pkg::stat_type                 stat,
   input  logic [ntcvt_pkg::CHAN_W-1:0]        in_chan,
   input  logic [ntcvt_pkg::VIN_W-1:0]         in_mv,
   input  logic                                in_link,
   input  logic                                out_ready,
   output logic                                out_valid,
   output logic [ntcvt_pkg::CHAN_W-1:0]        out_chan,
   output logic signed [ntcvt_pkg::T_W-1:0]    out_temp,
   output logic                                out_ok
);

   logic [ntcvt_pkg::CHAN_W-1:0]     chan_ff;
   logic [ntcvt_pkg::VIN_W-1:0]      mv_ff;
   logic                             link_ff;
   logic [ntcvt_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [ntcvt_pkg::MV_W-1:0]       dv_ff, off_ff;
   logic [ntcvt_pkg::DT_W-1:0]       dt_ff;
   logic signed [ntcvt_pkg::T_W-1:0] t0_ff;
   logic                             ok_ff;
   logic [ntcvt_pkg::PROD_W-1:0]     quo_ff;
   logic [ntcvt_pkg::MV_W:0]         rem_ff;
   logic [ntcvt_pkg::DCNT_W-1:0]     dcnt_ff;
   logic                             out_valid_ff;
   logic [ntcvt_pkg::CHAN_W-1:0]     out_chan_ff;
   logic signed [ntcvt_pkg::T_W-1:0] out_temp_ff;
   logic                             out_ok_ff;

   ntcvt_pkg::bp_type                bp_hi, bp_lo;
   logic [ntcvt_pkg::MV_W-1:0]       mv_low;
   logic signed [ntcvt_pkg::T_W-1:0] dt_full;
   logic [ntcvt_pkg::MV_W:0]         rem_shift, rem_sub;
   logic                             qbit;
   logic signed [ntcvt_pkg::T_W-1:0] temp_sum;

   assign idx_in = ntcvt_pkg::IDX_W'(idx_ff + 1'b1);
   assign bp_hi  = ntcvt_pkg::bp_lookup(idx_ff);
   assign bp_lo  = ntcvt_pkg::bp_lookup(idx_in);
   assign mv_low = mv_ff[ntcvt_pkg::MV_W-1:0];
   assign dt_full = bp_lo.tenths - bp_hi.tenths;

   assign rem_shift = {rem_ff[ntcvt_pkg::MV_W-1:0], quo_ff[ntcvt_pkg::PROD_W-1]};
   assign rem_sub   = rem_shift - {1'b0, dv_ff};
   assign qbit      = (rem_shift >= {1'b0, dv_ff});
   assign temp_sum  = t0_ff + $signed(quo_ff[ntcvt_pkg::T_W-1:0]);

   assign stat.in_range = link_ff && (mv_ff <= ntcvt_pkg::MV_MAX) && (mv_ff >= ntcvt_pkg::MV_MIN);
   assign stat.seg_hit  = (mv_low >= bp_lo.mv);
   assign stat.div_last = (dcnt_ff == ntcvt_pkg::DCNT_W'(ntcvt_pkg::PROD_W - 1));
   assign stat.out_free = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         chan_ff <= in_chan;
         mv_ff   <= in_mv;
         link_ff <= in_link;
      end
      if (cmd.start_search) begin
         idx_ff <= '0;
      end else if (cmd.inc_idx) begin
         idx_ff <= idx_in;
      end
      if (cmd.load_seg) begin
         dv_ff  <= bp_hi.mv - bp_lo.mv;
         off_ff <= bp_hi.mv - mv_low;
         dt_ff  <= dt_full[ntcvt_pkg::DT_W-1:0];
         t0_ff  <= bp_hi.tenths;
      end
      if (cmd.load_prod) begin
         quo_ff  <= ntcvt_pkg::PROD_W'(off_ff * dt_ff);
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= {quo_ff[ntcvt_pkg::PROD_W-2:0], qbit};
         rem_ff  <= qbit ? rem_sub : rem_shift;
         dcnt_ff <= ntcvt_pkg::DCNT_W'(dcnt_ff + 1'b1);
      end
      if (cmd.load_out) begin
         out_chan_ff <= chan_ff;
         out_temp_ff <= ok_ff ? temp_sum : '0;
         out_ok_ff   <= ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_in) begin
            ok_ff <= 1'b0;
         end else if (cmd.load_seg) begin
            ok_ff <= 1'b1;
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_chan  = out_chan_ff;
   assign out_temp  = out_temp_ff;
   assign out_ok    = out_ok_ff;

endmodule

/* hw/rtl/ntc_voltage_to_temperature.sv */
// An invalid reading goes from accept through the range check straight to finish; a valid
//   one also runs the serial search over the breakpoint table, the multiply and the
//   23-step restoring divide. One beat is in flight at a time: a new beat is taken only
//   after the previous result has been loaded into the result register.
// The result register lets the next beat in while a result waits.
// Synchronous active-high reset returns the sequencer to idle and drops rsp_tvalid.
`include "ntc_voltage_to_temperature_assert.svh"

module ntc_voltage_to_temperature (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] channel_index, [23:8] millivolts
   input  logic        req_tuser,   // [0] link_ok
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] channel_out, [19:8] temperature_tenths, zero pad
   output logic        rsp_tuser    // [0] reading_valid
);

   ntcvt_pkg::cmd_type                  cmd;
   ntcvt_pkg::stat_type                 stat;
   logic [ntcvt_pkg::CHAN_W-1:0]        out_chan;
   logic signed [ntcvt_pkg::T_W-1:0]    out_temp;

   ntcvt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ntcvt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .in_chan   (req_tdata[7:0]),
      .in_mv     (req_tdata[23:8]),
      .in_link   (req_tuser),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_chan  (out_chan),
      .out_temp  (out_temp),
      .out_ok    (rsp_tuser)
   );

   assign rsp_tdata = {4'd0, out_temp, out_chan};

   `NTCVT_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[19:8] == 12'd0, "invalid beat carries nonzero temperature")
   `NTCVT_ASSERT_NOW(a_temp_range, clock, reset, rsp_tvalid && rsp_tuser, ($signed(rsp_tdata[19:8]) >= -12'sd400) && ($signed(rsp_tdata[19:8]) <= 12'sd1200), "temperature outside table range")
   `NTCVT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "new beat taken while one is in progress")

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// Testbench for ntc_voltage_to_temperature: table-driven and random readings checked per beat.
module tb;

   typedef struct packed {
      logic [ntcvt_pkg::CHAN_W-1:0]     chan;
      logic signed [ntcvt_pkg::T_W-1:0] tenths;
      logic                             valid;
   } reading_type;

   typedef struct {
      logic [ntcvt_pkg::CHAN_W-1:0]     chan;
      logic [ntcvt_pkg::VIN_W-1:0]      mv;
      logic                             link_ok;
      bit                               typed;
      logic signed [ntcvt_pkg::T_W-1:0] tenths;
      logic                             valid;
   } stim_row_type;

   localparam int RANDOM_READINGS = 450;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [7:0] channel_index, [23:8] millivolts
   logic        req_tuser;   // [0] link_ok
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [7:0] channel_out, [19:8] temperature_tenths, zero pad
   logic        rsp_tuser;   // [0] reading_valid

   // breakpoints, voltage descending
   int knot_mv [ntcvt_pkg::TABLE_POINTS] = '{
      2440, 2420, 2400, 2380, 2350, 2320, 2270, 2230, 2170, 2110, 2050,
      1990, 1920, 1860, 1800, 1740, 1680, 1630, 1590, 1550, 1510, 1480,
      1450, 1430, 1400, 1380, 1370, 1350, 1340, 1330, 1320, 1310, 1300};
   int knot_tenths [ntcvt_pkg::TABLE_POINTS] = '{
      -400, -350, -300, -250, -200, -150, -100, -50, 0, 50, 100,
      150, 200, 250, 300, 350, 400, 450, 500, 550, 600, 650,
      700, 750, 800, 850, 900, 950, 1000, 1050, 1100, 1150, 1200};

   reading_type  pending_readings [$];
   stim_row_type directed_rows [$];
   int           mismatch_count = 0;
   bit           src_idle;
   bit           sink_stalls;

   ntc_voltage_to_temperature u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic reading_type predict_reading(logic [ntcvt_pkg::CHAN_W-1:0] chan,
                                                   logic [ntcvt_pkg::VIN_W-1:0] mv,
                                                   logic link_ok);
      reading_type r;
      int v;
      int hi;
      int lo;
      v = int'(mv);
      r.chan = chan;
      r.tenths = '0;
      r.valid = 1'b0;
      if (link_ok && v <= knot_mv[0] && v >= knot_mv[ntcvt_pkg::TABLE_POINTS-1]) begin
         for (int i = 0; i < ntcvt_pkg::TABLE_POINTS - 1; i++) begin
            hi = knot_mv[i];
            lo = knot_mv[i+1];
            if (!r.valid && v <= hi && v >= lo) begin
               r.valid = 1'b1;
               r.tenths = ntcvt_pkg::T_W'(knot_tenths[i]
                  + ((hi - v) * (knot_tenths[i+1] - knot_tenths[i])) / (hi - lo));
            end
         end
      end
      return r;
   endfunction

   // mostly short, now and then long
   function automatic int idle_length();
      if ($urandom_range(0, 7) == 0) begin
         return int'($urandom_range(20, 100));
      end
      return int'($urandom_range(1, 3));
   endfunction

   task automatic add_row(input logic [ntcvt_pkg::CHAN_W-1:0] chan,
                          input logic [ntcvt_pkg::VIN_W-1:0] mv,
                          input logic link_ok, input bit typed,
                          input logic signed [ntcvt_pkg::T_W-1:0] tenths, input logic valid);
      stim_row_type row;
      row.chan = chan;
      row.mv = mv;
      row.link_ok = link_ok;
      row.typed = typed;
      row.tenths = tenths;
      row.valid = valid;
      directed_rows.push_back(row);
   endtask

   task automatic send_reading(input logic [ntcvt_pkg::CHAN_W-1:0] chan,
                               input logic [ntcvt_pkg::VIN_W-1:0] mv,
                               input logic link_ok, input reading_type want);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {mv, chan};
      req_tuser  <= link_ok;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_readings.push_back(want);
      gap = (src_idle && $urandom_range(0, 2) == 0) ? idle_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // result sink with random backpressure
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (sink_stalls && $urandom_range(0, 2) == 0) begin
            n = idle_length();
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      reading_type want;
      reading_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.chan = rsp_tdata[7:0];
         got.tenths = rsp_tdata[19:8];
         got.valid = rsp_tuser;
         if (pending_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected beat: chan %0d tenths %0d valid %0b",
                        got.chan, got.tenths, got.valid);
            end
         end else begin
            want = pending_readings.pop_front();
            if (got.chan !== want.chan || got.tenths !== want.tenths
                || got.valid !== want.valid) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: chan %0d tenths %0d valid %0b, want %0d %0d %0b",
                           got.chan, got.tenths, got.valid,
                           want.chan, want.tenths, want.valid);
               end
            end
         end
      end
   end

   initial begin
      reading_type                  want;
      logic [ntcvt_pkg::CHAN_W-1:0] chan;
      logic [ntcvt_pkg::VIN_W-1:0]  mv;
      logic                         ok;
      int                           pick;
      int                           phase;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      rsp_tready  = 1'b0;
      src_idle    = 1'b0;
      sink_stalls = 1'b0;

      // range ends, out of range, bad link, exact breakpoints, segment interiors
      add_row(8'h00, 16'd2440,  1'b1, 1'b1, -12'sd400, 1'b1);
      add_row(8'hFF, 16'd1300,  1'b1, 1'b1, 12'sd1200, 1'b1);
      add_row(8'h5A, 16'd2441,  1'b1, 1'b1, 12'sd0,    1'b0);
      add_row(8'hA5, 16'd1299,  1'b1, 1'b1, 12'sd0,    1'b0);
      add_row(8'h01, 16'd0,     1'b1, 1'b1, 12'sd0,    1'b0);
      add_row(8'h02, 16'hFFFF,  1'b1, 1'b1, 12'sd0,    1'b0);
      add_row(8'h03, 16'd2170,  1'b0, 1'b1, 12'sd0,    1'b0);
      add_row(8'h04, 16'hFFFF,  1'b0, 1'b1, 12'sd0,    1'b0);
      add_row(8'h05, 16'd2170,  1'b1, 1'b1, 12'sd0,    1'b1);
      add_row(8'h06, 16'd1860,  1'b1, 1'b1, 12'sd250,  1'b1);
      add_row(8'h07, 16'd2420,  1'b1, 1'b1, -12'sd350, 1'b1);
      add_row(8'h08, 16'd1310,  1'b1, 1'b1, 12'sd1150, 1'b1);
      add_row(8'h10, 16'hAAAA,  1'b1, 1'b1, 12'sd0,    1'b0);
      add_row(8'h11, 16'h5555,  1'b1, 1'b1, 12'sd0,    1'b0);
      add_row(8'h09, 16'd2430,  1'b1, 1'b0, 12'sd0,    1'b0);
      add_row(8'h0A, 16'd1305,  1'b1, 1'b0, 12'sd0,    1'b0);
      add_row(8'h0B, 16'd2439,  1'b1, 1'b0, 12'sd0,    1'b0);
      add_row(8'h0C, 16'd1301,  1'b1, 1'b0, 12'sd0,    1'b0);
      add_row(8'h0D, 16'd2000,  1'b1, 1'b0, 12'sd0,    1'b0);
      add_row(8'h0E, 16'd1745,  1'b1, 1'b0, 12'sd0,    1'b0);
      add_row(8'h0F, 16'd1375,  1'b1, 1'b0, 12'sd0,    1'b0);
      add_row(8'h80, 16'd2047,  1'b1, 1'b0, 12'sd0,    1'b0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed) begin
            want.chan = directed_rows[i].chan;
            want.tenths = directed_rows[i].tenths;
            want.valid = directed_rows[i].valid;
         end else begin
            want = predict_reading(directed_rows[i].chan, directed_rows[i].mv,
                                   directed_rows[i].link_ok);
         end
         send_reading(directed_rows[i].chan, directed_rows[i].mv,
                      directed_rows[i].link_ok, want);
      end

      for (int n = 0; n < RANDOM_READINGS; n++) begin
         // four phases: no idling, source gaps, sink stalls, both
         phase = n / 113;
         src_idle = phase[0];
         sink_stalls = phase[1];
         chan = ntcvt_pkg::CHAN_W'($urandom_range(0, 255));
         ok = 1'b1;
         pick = int'($urandom_range(0, 99));
         if (pick < 60) begin
            mv = ntcvt_pkg::VIN_W'($urandom_range(knot_mv[ntcvt_pkg::TABLE_POINTS-1],
                                                  knot_mv[0]));
         end else if (pick < 72) begin
            mv = ntcvt_pkg::VIN_W'(knot_mv[$urandom_range(0, ntcvt_pkg::TABLE_POINTS - 1)]);
         end else if (pick < 80) begin
            mv = ($urandom_range(0, 1) == 0) ? ntcvt_pkg::VIN_W'($urandom_range(1290, 1310))
                                             : ntcvt_pkg::VIN_W'($urandom_range(2430, 2450));
         end else if (pick < 90) begin
            mv = ntcvt_pkg::VIN_W'($urandom_range(0, 65535));
         end else begin
            mv = ($urandom_range(0, 1) == 0) ? ntcvt_pkg::VIN_W'($urandom_range(0, 65535))
                                             : ntcvt_pkg::VIN_W'($urandom_range(1300, 2440));
            ok = 1'($urandom_range(0, 1));
         end
         send_reading(chan, mv, ok, predict_reading(chan, mv, ok));
      end
      req_tvalid <= 1'b0;

      while (pending_readings.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
